FILE: hdl/assert_macros.svh
// Assertion macros used by the controller of the translation buffer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// When cond holds at a clock edge, prop must hold at the same edge.
`define ASSERT_SAME(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (prop)) \
		else $error("assertion failed");

// When cond holds at a clock edge, prop must hold at the next edge.
`define ASSERT_NEXT(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (prop)) \
		else $error("assertion failed");

`endif

FILE: hdl/tlbl_pkg.sv
// Package with the types, codes and defaults of the two-level translation buffer.
`default_nettype none

package tlbl_pkg;

	localparam int DEF_L1_ENTRIES   = 16;
	localparam int DEF_L2_ENTRIES   = 64;
	localparam int DEF_OFFSET_BITS  = 12;
	localparam int DEF_ADDRESS_BITS = 32;

	localparam int PPN_BITS   = 20;
	localparam int STAMP_BITS = 64;

	typedef enum logic [1:0] {
		OP_READ  = 2'd0,
		OP_WR    = 2'd1,
		OP_INV   = 2'd2,
		OP_FILL  = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		KIND_XLATE = 3'd0,
		KIND_WALK  = 3'd1,
		KIND_WB    = 3'd2,
		KIND_INV   = 3'd3,
		KIND_IGN   = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		SRC_L1   = 2'd0,
		SRC_L2   = 2'd1,
		SRC_WALK = 2'd2
	} src_t;

	typedef enum logic [3:0] {
		ACT_NONE,
		ACT_LOAD,
		ACT_SCAN1,
		ACT_SCAN2,
		ACT_SCAN2V,
		ACT_L1_TOUCH,
		ACT_L1_INV,
		ACT_L1_INSTALL,
		ACT_L2_TOUCH,
		ACT_L2_INV,
		ACT_L2_FINSTALL,
		ACT_L2_VTOUCH,
		ACT_L2_VINSTALL,
		ACT_MISS
	} dp_act_t;

	typedef enum logic [2:0] {
		EMIT_NONE,
		EMIT_XL,
		EMIT_WALK,
		EMIT_WB,
		EMIT_INV,
		EMIT_IGN
	} emit_t;

	typedef struct packed {
		dp_act_t act;
		emit_t   emit;
	} cmd_t;

	typedef struct packed {
		opcode_t op;
		logic    fill_ok;
		logic    busy1;
		logic    busy2;
		logic    hit1;
		logic    free1;
		logic    hit2;
		logic    wb_needed;
		logic    out_free;
		logic    clearing;
	} sts_t;

	typedef enum logic [4:0] {
		S_CLEAR,
		S_IDLE,
		S_DISPATCH,
		S_W1,
		S_SCAN2,
		S_W2,
		S_E_WBF,
		S_SCAN1,
		S_L1_PLACE,
		S_W2V,
		S_E_WBV,
		S_L1_INST,
		S_E_XL,
		S_E_WALK,
		S_E_INV,
		S_E_IGN
	} state_t;

endpackage

`default_nettype wire

FILE: hdl/two_level_tlb_lru.sv
// An L1 hit searches L1 and then registers the result item. A miss adds a search of L2; an L2 hit
// then places the entry in L1, and a fill with evictions searches L2, L1 and L2 again, each search
// examining one entry per cycle.
// One item is in work at a time; the next is accepted once the last result is registered.
// Reset: asynchronous; a clearing sweep of both levels follows,
// during which req_stall stays high.
`default_nettype none

module two_level_tlb_lru
	import tlbl_pkg::*;
#(
	parameter int L1_ENTRIES   = DEF_L1_ENTRIES,
	parameter int L2_ENTRIES   = DEF_L2_ENTRIES,
	parameter int OFFSET_BITS  = DEF_OFFSET_BITS,
	parameter int ADDRESS_BITS = DEF_ADDRESS_BITS
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	output logic                     req_stall,
	input  wire logic [1:0]          opcode,
	input  wire logic [31:0]         vaddr,
	input  wire logic [PPN_BITS-1:0] fill_page,
	output logic                     rsp_valid,
	input  wire logic                rsp_stall,
	output logic [2:0]               kind,
	output logic [31:0]              address,
	output logic [1:0]               source,
	output logic                     is_write,
	output logic                     last
);

	cmd_t cmd;
	sts_t sts;

	// Sequencing.
	tlbl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Storage, search and result path.
	tlbl_datapath #(
		.L1_ENTRIES   (L1_ENTRIES),
		.L2_ENTRIES   (L2_ENTRIES),
		.OFFSET_BITS  (OFFSET_BITS),
		.ADDRESS_BITS (ADDRESS_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.opcode          (opcode),
		.vaddr           (vaddr),
		.fill_page       (fill_page),
		.rsp_valid       (rsp_valid),
		.rsp_stall       (rsp_stall),
		.kind            (kind),
		.address         (address),
		.source          (source),
		.is_write        (is_write),
		.last            (last)
	);

endmodule

`default_nettype wire

FILE: hdl/tlbl_level.sv
// One fully associative level: entry and stamp memories with a sequential search engine.
`default_nettype none

module tlbl_level
	import tlbl_pkg::*;
#(
	parameter int N     = DEF_L1_ENTRIES,
	parameter int VPN_W = DEF_ADDRESS_BITS - DEF_OFFSET_BITS
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          scan_start,
	input  wire logic [VPN_W-1:0]              scan_key,
	input  wire logic                          ent_we,
	input  wire logic                          stamp_we,
	input  wire logic [((N > 1) ? $clog2(N) : 1)-1:0] wr_idx,
	input  wire logic [VPN_W+PPN_BITS+1:0]     wr_ent,
	input  wire logic [STAMP_BITS-1:0]         wr_stamp,
	output logic                               busy,
	output logic                               clearing,
	output logic                               hit,
	output logic [((N > 1) ? $clog2(N) : 1)-1:0] hit_idx,
	output logic [VPN_W+PPN_BITS+1:0]          hit_ent,
	output logic                               free,
	output logic [((N > 1) ? $clog2(N) : 1)-1:0] free_idx,
	output logic [((N > 1) ? $clog2(N) : 1)-1:0] lru_idx,
	output logic [VPN_W+PPN_BITS+1:0]          lru_ent
);

	localparam int IDX_W = (N > 1) ? $clog2(N) : 1;
	localparam int ENT_W = VPN_W + PPN_BITS + 2;
	localparam logic [IDX_W-1:0] LAST = IDX_W'(N - 1);

	logic [ENT_W-1:0]      ent_mem [N];
	logic [STAMP_BITS-1:0] stamp_mem [N];

	logic                  clr_q;
	logic [IDX_W-1:0]      clr_idx_q;
	logic                  scan_q;
	logic [IDX_W-1:0]      rd_idx_q;
	logic                  vld_s1;
	logic [IDX_W-1:0]      idx_s1;
	logic [ENT_W-1:0]      ent_s1;
	logic [STAMP_BITS-1:0] stamp_s1;
	logic [VPN_W-1:0]      key_q;
	logic                  hit_q;
	logic                  free_q;
	logic [IDX_W-1:0]      hit_idx_q;
	logic [ENT_W-1:0]      hit_ent_q;
	logic [IDX_W-1:0]      free_idx_q;
	logic [IDX_W-1:0]      lru_idx_q;
	logic [ENT_W-1:0]      lru_ent_q;
	logic [STAMP_BITS-1:0] best_stamp_q;

	logic                  e_valid;
	logic [VPN_W-1:0]      e_vpn;

	assign e_valid = ent_s1[ENT_W-1];
	assign e_vpn   = ent_s1[VPN_W+PPN_BITS-1:PPN_BITS];

	// Memory ports: the clearing sweep owns the entry write port after reset.
	always_ff @(posedge clk) begin
		if (clr_q || ent_we) begin
			ent_mem[clr_q ? clr_idx_q : wr_idx] <= clr_q ? '0 : wr_ent;
		end
		if (stamp_we) begin
			stamp_mem[wr_idx] <= wr_stamp;
		end
		ent_s1   <= ent_mem[rd_idx_q];
		stamp_s1 <= stamp_mem[rd_idx_q];
	end

	// Clearing sweep and read address sequencing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_idx_q <= '0;
			scan_q    <= 1'b0;
			rd_idx_q  <= '0;
			vld_s1    <= 1'b0;
			idx_s1    <= '0;
			hit_q     <= 1'b0;
			free_q    <= 1'b0;
		end else begin
			if (clr_q) begin
				clr_idx_q <= clr_idx_q + 1'b1;
				if (clr_idx_q == LAST) begin
					clr_q <= 1'b0;
				end
			end
			vld_s1 <= scan_q;
			idx_s1 <= rd_idx_q;
			if (scan_start) begin
				scan_q   <= 1'b1;
				rd_idx_q <= '0;
				hit_q    <= 1'b0;
				free_q   <= 1'b0;
			end else begin
				if (scan_q) begin
					if (rd_idx_q == LAST) begin
						scan_q <= 1'b0;
					end else begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end
				end
				if (vld_s1) begin
					if (e_valid && (e_vpn == key_q) && !hit_q) begin
						hit_q <= 1'b1;
					end
					if (!e_valid && !free_q) begin
						free_q <= 1'b1;
					end
				end
			end
		end
	end

	// Search results: first match, first free slot, oldest stamp (latest index on ties).
	always_ff @(posedge clk) begin
		if (scan_start) begin
			key_q <= scan_key;
		end
		if (vld_s1) begin
			if (e_valid && (e_vpn == key_q) && !hit_q) begin
				hit_idx_q <= idx_s1;
				hit_ent_q <= ent_s1;
			end
			if (!e_valid && !free_q) begin
				free_idx_q <= idx_s1;
			end
			if ((idx_s1 == '0) || (stamp_s1 <= best_stamp_q)) begin
				best_stamp_q <= stamp_s1;
				lru_idx_q    <= idx_s1;
				lru_ent_q    <= ent_s1;
			end
		end
	end

	assign busy     = scan_q | vld_s1;
	assign clearing = clr_q;
	assign hit      = hit_q;
	assign hit_idx  = hit_idx_q;
	assign hit_ent  = hit_ent_q;
	assign free     = free_q;
	assign free_idx = free_idx_q;
	assign lru_idx  = lru_idx_q;
	assign lru_ent  = lru_ent_q;

endmodule

`default_nettype wire

FILE: hdl/tlbl_datapath.sv
// Datapath: both levels, item registers, pending walk request, access clock and result register.
`default_nettype none

module tlbl_datapath
	import tlbl_pkg::*;
#(
	parameter int L1_ENTRIES   = DEF_L1_ENTRIES,
	parameter int L2_ENTRIES   = DEF_L2_ENTRIES,
	parameter int OFFSET_BITS  = DEF_OFFSET_BITS,
	parameter int ADDRESS_BITS = DEF_ADDRESS_BITS
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire cmd_t                cmd,
	output sts_t                     sts,
	input  wire logic [1:0]          opcode,
	input  wire logic [31:0]         vaddr,
	input  wire logic [PPN_BITS-1:0] fill_page,
	output logic                     rsp_valid,
	input  wire logic                rsp_stall,
	output logic [2:0]               kind,
	output logic [31:0]              address,
	output logic [1:0]               source,
	output logic                     is_write,
	output logic                     last
);

	localparam int VPN_W  = ADDRESS_BITS - OFFSET_BITS;
	localparam int ENT_W  = VPN_W + PPN_BITS + 2;
	localparam int IDX1_W = (L1_ENTRIES > 1) ? $clog2(L1_ENTRIES) : 1;
	localparam int IDX2_W = (L2_ENTRIES > 1) ? $clog2(L2_ENTRIES) : 1;
	localparam logic [31:0] VA_MASK  =
		(ADDRESS_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << ADDRESS_BITS) - 64'd1);
	localparam logic [31:0] OFS_MASK = 32'((64'd1 << OFFSET_BITS) - 64'd1);

	// Item and translation registers.
	opcode_t               op_q;
	logic [31:0]           va_q;
	logic                  wr_q;
	logic [VPN_W-1:0]      key_q;
	logic [PPN_BITS-1:0]   new_ppn_q;
	logic                  new_dirty_q;
	logic [PPN_BITS-1:0]   res_ppn_q;
	src_t                  src_q;
	logic [PPN_BITS-1:0]   wb_ppn_q;
	logic [31:0]           pend_va_q;
	logic                  pend_wr_q;
	logic                  pend_valid_q;
	logic                  fill_ok_q;
	logic [STAMP_BITS-1:0] clock_q;

	logic                  out_valid_q;
	logic [2:0]            out_kind_q;
	logic [31:0]           out_addr_q;
	logic [1:0]            out_src_q;
	logic                  out_wr_q;
	logic                  out_last_q;

	logic [31:0]           va_in;
	logic [VPN_W-1:0]      vpn_in;
	logic [VPN_W-1:0]      vpn_pend;
	logic [STAMP_BITS-1:0] next_stamp;
	logic                  out_free;
	logic                  stamp_tick;

	// Level one signals.
	logic                  l1_busy, l1_clr, l1_hit, l1_free;
	logic [IDX1_W-1:0]     l1_hit_idx, l1_free_idx, l1_lru_idx, l1_widx;
	logic [ENT_W-1:0]      l1_hit_ent, l1_lru_ent, l1_went;
	logic                  l1_ent_we, l1_st_we;

	// Level two signals.
	logic                  l2_busy, l2_clr, l2_hit, l2_free;
	logic [IDX2_W-1:0]     l2_hit_idx, l2_free_idx, l2_lru_idx, l2_widx;
	logic [ENT_W-1:0]      l2_hit_ent, l2_lru_ent, l2_went;
	logic                  l2_ent_we, l2_st_we;
	logic [VPN_W-1:0]      l2_key;

	assign va_in      = vaddr & VA_MASK;
	assign vpn_in     = VPN_W'(va_in >> OFFSET_BITS);
	assign vpn_pend   = VPN_W'(pend_va_q >> OFFSET_BITS);
	assign next_stamp = clock_q + 1'b1;
	assign out_free   = !out_valid_q || !rsp_stall;
	assign l2_key     = (cmd.act == ACT_SCAN2V) ? l1_lru_ent[VPN_W+PPN_BITS-1:PPN_BITS] : key_q;

	tlbl_level #(
		.N     (L1_ENTRIES),
		.VPN_W (VPN_W)
	) u_l1 (
		.clk        (clk),
		.arst_n     (arst_n),
		.scan_start (cmd.act == ACT_SCAN1),
		.scan_key   (key_q),
		.ent_we     (l1_ent_we),
		.stamp_we   (l1_st_we),
		.wr_idx     (l1_widx),
		.wr_ent     (l1_went),
		.wr_stamp   (next_stamp),
		.busy       (l1_busy),
		.clearing   (l1_clr),
		.hit        (l1_hit),
		.hit_idx    (l1_hit_idx),
		.hit_ent    (l1_hit_ent),
		.free       (l1_free),
		.free_idx   (l1_free_idx),
		.lru_idx    (l1_lru_idx),
		.lru_ent    (l1_lru_ent)
	);

	tlbl_level #(
		.N     (L2_ENTRIES),
		.VPN_W (VPN_W)
	) u_l2 (
		.clk        (clk),
		.arst_n     (arst_n),
		.scan_start ((cmd.act == ACT_SCAN2) || (cmd.act == ACT_SCAN2V)),
		.scan_key   (l2_key),
		.ent_we     (l2_ent_we),
		.stamp_we   (l2_st_we),
		.wr_idx     (l2_widx),
		.wr_ent     (l2_went),
		.wr_stamp   (next_stamp),
		.busy       (l2_busy),
		.clearing   (l2_clr),
		.hit        (l2_hit),
		.hit_idx    (l2_hit_idx),
		.hit_ent    (l2_hit_ent),
		.free       (l2_free),
		.free_idx   (l2_free_idx),
		.lru_idx    (l2_lru_idx),
		.lru_ent    (l2_lru_ent)
	);

	// Level one write port.
	always_comb begin
		l1_ent_we = 1'b0;
		l1_st_we  = 1'b0;
		l1_widx   = l1_hit_idx;
		l1_went   = l1_hit_ent;
		unique case (cmd.act)
			ACT_L1_TOUCH: begin
				l1_ent_we          = 1'b1;
				l1_st_we           = 1'b1;
				l1_went[ENT_W-2]   = l1_hit_ent[ENT_W-2] | wr_q;
			end
			ACT_L1_INV: begin
				l1_ent_we          = 1'b1;
				l1_went[ENT_W-1]   = 1'b0;
			end
			ACT_L1_INSTALL: begin
				l1_ent_we = 1'b1;
				l1_st_we  = 1'b1;
				l1_widx   = l1_free ? l1_free_idx : l1_lru_idx;
				l1_went   = {1'b1, new_dirty_q, key_q, new_ppn_q};
			end
			default: begin
			end
		endcase
	end

	// Level two write port.
	always_comb begin
		l2_ent_we = 1'b0;
		l2_st_we  = 1'b0;
		l2_widx   = l2_hit_idx;
		l2_went   = l2_hit_ent;
		unique case (cmd.act)
			ACT_L2_TOUCH: begin
				l2_ent_we        = 1'b1;
				l2_st_we         = 1'b1;
				l2_went[ENT_W-2] = l2_hit_ent[ENT_W-2] | wr_q;
			end
			ACT_L2_VTOUCH: begin
				l2_ent_we        = 1'b1;
				l2_st_we         = 1'b1;
				l2_went[ENT_W-2] = l2_hit_ent[ENT_W-2] | l1_lru_ent[ENT_W-2];
			end
			ACT_L2_INV: begin
				l2_ent_we        = 1'b1;
				l2_went[ENT_W-1] = 1'b0;
			end
			ACT_L2_FINSTALL: begin
				l2_ent_we = 1'b1;
				l2_st_we  = 1'b1;
				l2_widx   = l2_free ? l2_free_idx : l2_lru_idx;
				l2_went   = {1'b1, new_dirty_q, key_q, new_ppn_q};
			end
			ACT_L2_VINSTALL: begin
				l2_ent_we = 1'b1;
				l2_st_we  = 1'b1;
				l2_widx   = l2_free ? l2_free_idx : l2_lru_idx;
				l2_went   = {1'b1, l1_lru_ent[ENT_W-2:0]};
			end
			default: begin
			end
		endcase
	end

	assign stamp_tick = l1_st_we | l2_st_we;

	// Control registers: access clock, pending request flag, fill flag, opcode, result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_q      <= '0;
			pend_valid_q <= 1'b0;
			fill_ok_q    <= 1'b0;
			out_valid_q  <= 1'b0;
			op_q         <= OP_READ;
		end else begin
			if (stamp_tick) begin
				clock_q <= next_stamp;
			end
			if (cmd.act == ACT_LOAD) begin
				op_q <= opcode_t'(opcode);
				if (opcode_t'(opcode) == OP_FILL) begin
					fill_ok_q    <= pend_valid_q;
					pend_valid_q <= 1'b0;
				end
			end
			if (cmd.act == ACT_MISS) begin
				pend_valid_q <= 1'b1;
			end
			if (cmd.emit != EMIT_NONE) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers of the item in work.
	always_ff @(posedge clk) begin
		unique case (cmd.act) inside
			ACT_LOAD: begin
				wr_q <= (opcode_t'(opcode) == OP_WR);
				if (opcode_t'(opcode) == OP_FILL) begin
					va_q        <= pend_va_q;
					key_q       <= vpn_pend;
					new_ppn_q   <= fill_page;
					new_dirty_q <= pend_wr_q;
					res_ppn_q   <= fill_page;
					src_q       <= SRC_WALK;
				end else begin
					va_q  <= va_in;
					key_q <= vpn_in;
				end
			end
			ACT_L1_TOUCH: begin
				res_ppn_q <= l1_hit_ent[PPN_BITS-1:0];
				src_q     <= SRC_L1;
			end
			ACT_L2_TOUCH: begin
				new_ppn_q   <= l2_hit_ent[PPN_BITS-1:0];
				new_dirty_q <= l2_hit_ent[ENT_W-2] | wr_q;
				res_ppn_q   <= l2_hit_ent[PPN_BITS-1:0];
				src_q       <= SRC_L2;
			end
			ACT_L2_FINSTALL, ACT_L2_VINSTALL: begin
				wb_ppn_q <= l2_lru_ent[PPN_BITS-1:0];
			end
			ACT_MISS: begin
				pend_va_q <= va_q;
				pend_wr_q <= wr_q;
			end
			default: begin
			end
		endcase
	end

	// Result register.
	always_ff @(posedge clk) begin
		unique case (cmd.emit)
			EMIT_XL: begin
				out_kind_q <= KIND_XLATE;
				out_addr_q <= 32'({32'd0, res_ppn_q} << OFFSET_BITS) | (va_q & OFS_MASK);
				out_src_q  <= src_q;
				out_wr_q   <= 1'b0;
				out_last_q <= 1'b1;
			end
			EMIT_WALK: begin
				out_kind_q <= KIND_WALK;
				out_addr_q <= va_q;
				out_src_q  <= SRC_L1;
				out_wr_q   <= wr_q;
				out_last_q <= 1'b1;
			end
			EMIT_WB: begin
				out_kind_q <= KIND_WB;
				out_addr_q <= 32'({32'd0, wb_ppn_q} << OFFSET_BITS);
				out_src_q  <= SRC_L1;
				out_wr_q   <= 1'b0;
				out_last_q <= 1'b0;
			end
			EMIT_INV: begin
				out_kind_q <= KIND_INV;
				out_addr_q <= va_q;
				out_src_q  <= SRC_L1;
				out_wr_q   <= 1'b0;
				out_last_q <= 1'b1;
			end
			EMIT_IGN: begin
				out_kind_q <= KIND_IGN;
				out_addr_q <= '0;
				out_src_q  <= SRC_L1;
				out_wr_q   <= 1'b0;
				out_last_q <= 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Status toward the controller.
	always_comb begin
		sts.op        = op_q;
		sts.fill_ok   = fill_ok_q;
		sts.busy1     = l1_busy;
		sts.busy2     = l2_busy;
		sts.hit1      = l1_hit;
		sts.free1     = l1_free;
		sts.hit2      = l2_hit;
		sts.wb_needed = !l2_free && l2_lru_ent[ENT_W-2];
		sts.out_free  = out_free;
		sts.clearing  = l1_clr | l2_clr;
	end

	assign rsp_valid = out_valid_q;
	assign kind      = out_kind_q;
	assign address   = out_addr_q;
	assign source    = out_src_q;
	assign is_write  = out_wr_q;
	assign last      = out_last_q;

endmodule

`default_nettype wire

FILE: hdl/tlbl_ctrl.sv
// Controller state machine that sequences searches, updates and result items.
`default_nettype none

`include "assert_macros.svh"

module tlbl_ctrl
	import tlbl_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	state_t state_q;
	state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d   = state_q;
		cmd.act   = ACT_NONE;
		cmd.emit  = EMIT_NONE;
		req_stall = 1'b1;
		unique case (state_q)
			S_CLEAR: begin
				if (!sts.clearing) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.act = ACT_LOAD;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				if (sts.op == OP_FILL) begin
					if (sts.fill_ok) begin
						cmd.act = ACT_SCAN2;
						state_d = S_W2;
					end else begin
						state_d = S_E_IGN;
					end
				end else begin
					cmd.act = ACT_SCAN1;
					state_d = S_W1;
				end
			end
			S_W1: begin
				if (!sts.busy1) begin
					unique case (sts.op) inside
						OP_READ, OP_WR: begin
							if (sts.hit1) begin
								cmd.act = ACT_L1_TOUCH;
								state_d = S_E_XL;
							end else begin
								cmd.act = ACT_SCAN2;
								state_d = S_W2;
							end
						end
						OP_INV: begin
							if (sts.hit1) begin
								cmd.act = ACT_L1_INV;
							end
							state_d = S_SCAN2;
						end
						OP_FILL: begin
							state_d = S_L1_PLACE;
						end
						default: begin
						end
					endcase
				end
			end
			S_SCAN2: begin
				cmd.act = ACT_SCAN2;
				state_d = S_W2;
			end
			S_W2: begin
				if (!sts.busy2) begin
					unique case (sts.op) inside
						OP_READ, OP_WR: begin
							if (sts.hit2) begin
								cmd.act = ACT_L2_TOUCH;
								state_d = S_L1_PLACE;
							end else begin
								cmd.act = ACT_MISS;
								state_d = S_E_WALK;
							end
						end
						OP_INV: begin
							if (sts.hit2) begin
								cmd.act = ACT_L2_INV;
							end
							state_d = S_E_INV;
						end
						OP_FILL: begin
							cmd.act = ACT_L2_FINSTALL;
							state_d = sts.wb_needed ? S_E_WBF : S_SCAN1;
						end
						default: begin
						end
					endcase
				end
			end
			S_E_WBF: begin
				if (sts.out_free) begin
					cmd.emit = EMIT_WB;
					state_d  = S_SCAN1;
				end
			end
			S_SCAN1: begin
				cmd.act = ACT_SCAN1;
				state_d = S_W1;
			end
			S_L1_PLACE: begin
				if (sts.free1) begin
					cmd.act = ACT_L1_INSTALL;
					state_d = S_E_XL;
				end else begin
					cmd.act = ACT_SCAN2V;
					state_d = S_W2V;
				end
			end
			S_W2V: begin
				if (!sts.busy2) begin
					if (sts.hit2) begin
						cmd.act = ACT_L2_VTOUCH;
						state_d = S_L1_INST;
					end else begin
						cmd.act = ACT_L2_VINSTALL;
						state_d = sts.wb_needed ? S_E_WBV : S_L1_INST;
					end
				end
			end
			S_E_WBV: begin
				if (sts.out_free) begin
					cmd.emit = EMIT_WB;
					state_d  = S_L1_INST;
				end
			end
			S_L1_INST: begin
				cmd.act = ACT_L1_INSTALL;
				state_d = S_E_XL;
			end
			S_E_XL: begin
				if (sts.out_free) begin
					cmd.emit = EMIT_XL;
					state_d  = S_IDLE;
				end
			end
			S_E_WALK: begin
				if (sts.out_free) begin
					cmd.emit = EMIT_WALK;
					state_d  = S_IDLE;
				end
			end
			S_E_INV: begin
				if (sts.out_free) begin
					cmd.emit = EMIT_INV;
					state_d  = S_IDLE;
				end
			end
			S_E_IGN: begin
				if (sts.out_free) begin
					cmd.emit = EMIT_IGN;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// A result item is written only into a free result register.
	`ASSERT_SAME(a_emit_free, clk, arst_n, cmd.emit != EMIT_NONE, sts.out_free)
	// A search never starts while the same level is still searching.
	`ASSERT_SAME(a_scan1_idle, clk, arst_n, cmd.act == ACT_SCAN1, !sts.busy1)
	`ASSERT_SAME(a_scan2_idle, clk, arst_n,
		(cmd.act == ACT_SCAN2) || (cmd.act == ACT_SCAN2V), !sts.busy2)
	// Items are taken only after the clearing sweep has finished.
	`ASSERT_SAME(a_idle_cleared, clk, arst_n, state_q == S_IDLE, !sts.clearing)
	// A started search is reported busy in the following cycle.
	`ASSERT_NEXT(a_scan_busy, clk, arst_n, cmd.act == ACT_SCAN1, sts.busy1)

endmodule

`default_nettype wire
